// File: design/rrts_pkg.sv
package rrts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int SUM_W     = IDX_W + 1;

    localparam int ID_W      = 16;
    localparam int BURST_W   = 16;
    localparam int QUANT_W   = 8;
    localparam int STATUS_W  = 3;
    localparam int LEFT_W    = 5;
    localparam int FUNC_W    = 2;

    localparam logic [QUANT_W-1:0] QUANTUM_RST = QUANT_W'(10);

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
    } t_entry;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_RUN    = 2'd1,
        FUNC_REMOVE = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_ZERO_BURST = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_NOT_FOUND  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } t_state;

    // ring slot of the entry at offset rel from the head; rel never exceeds MAX_TASKS
    function automatic t_idx slot_at(t_idx head, t_cnt rel);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, head} + SUM_W'(rel);
        if (sum >= SUM_W'(MAX_TASKS)) begin
            sum = sum - SUM_W'(MAX_TASKS);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// File: design/rrts_ram.sv
module rrts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/round_robin_task_scheduler.sv
// Channel   Dir  Handshake              Payload
// s         in   i_s_tvalid/o_s_tready  tuser: func; tdata: task_burst, task_id
// m         out  o_m_tvalid/i_m_tready  tuser: status; tdata: served_id, slice,
//                                       finished, tasks_left
// cfg       in   i_cfg_we               i_cfg_wdata: quantum
//
// Add, unused code and empty-table items go from idle straight to the response state;
// a run slice reads its entry first. Remove scans and a drop behind the head compacts, one
// entry per cycle each, MAX_TASKS entries at most together, as the task table RAM
// has a single read port.
// Reset is synchronous and active low; the table contents are not cleared.
// A result waits in the output register while the next transaction is taken.
module round_robin_task_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] task_burst, [31:16] task_id
    input  logic [1:0]  i_s_tuser,   // [1:0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] served_id, [23:16] slice_length,
                                     // [24] finished, [29:25] tasks_left, rest zero
    output logic [2:0]  o_m_tuser,   // [2:0] status
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);

    localparam int SUM_W = rrts_pkg::SUM_W;
    localparam int CNT_W = rrts_pkg::CNT_W;
    localparam int WIDE_W = rrts_pkg::CNT_W + rrts_pkg::LEFT_W;

    rrts_pkg::t_state               r_state, n_state;
    logic [rrts_pkg::QUANT_W-1:0]   r_quantum;
    rrts_pkg::t_idx                 r_head, n_head;
    rrts_pkg::t_idx                 r_cur, n_cur;
    rrts_pkg::t_cnt                 r_count, n_count;
    logic [rrts_pkg::ID_W-1:0]      r_next_id, n_next_id;
    logic [rrts_pkg::ID_W-1:0]      r_want, n_want;
    rrts_pkg::t_idx                 r_k, n_k;

    rrts_pkg::t_status              r_res_status, n_res_status;
    logic [rrts_pkg::ID_W-1:0]      r_res_served, n_res_served;
    logic [rrts_pkg::QUANT_W-1:0]   r_res_slice, n_res_slice;
    logic                           r_res_done, n_res_done;

    logic                           r_out_valid;
    rrts_pkg::t_status              r_out_status;
    logic [rrts_pkg::ID_W-1:0]      r_out_served;
    logic [rrts_pkg::QUANT_W-1:0]   r_out_slice;
    logic                           r_out_done;
    logic [rrts_pkg::LEFT_W-1:0]    r_out_left;

    logic                           s_acc;
    logic                           out_load;
    rrts_pkg::t_func                in_func;
    logic [rrts_pkg::BURST_W-1:0]   in_burst;
    logic [rrts_pkg::ID_W-1:0]      in_id;

    logic                           ram_we;
    rrts_pkg::t_idx                 ram_waddr, ram_raddr;
    rrts_pkg::t_entry               ram_wdata, ram_rdata;

    logic                           drop_go;
    rrts_pkg::t_idx                 drop_r;
    rrts_pkg::t_cnt                 drop_cnt;
    rrts_pkg::t_idx                 drop_cur;
    logic [WIDE_W-1:0]              count_wide;

    assign o_s_tready = (r_state == rrts_pkg::S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign in_func    = rrts_pkg::t_func'(i_s_tuser[1:0]);
    assign in_burst   = i_s_tdata[15:0];
    assign in_id      = i_s_tdata[31:16];
    assign out_load   = (r_state == rrts_pkg::S_RESP) && (!r_out_valid || i_m_tready);
    assign count_wide = WIDE_W'(r_count);

    rrts_ram #(
        .WIDTH ($bits(rrts_pkg::t_entry)),
        .DEPTH (rrts_pkg::MAX_TASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrts_pkg::S_IDLE;
            r_quantum   <= rrts_pkg::QUANTUM_RST;
            r_head      <= '0;
            r_cur       <= '0;
            r_count     <= '0;
            r_next_id   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_cur     <= n_cur;
            r_count   <= n_count;
            r_next_id <= n_next_id;
            if (i_cfg_we) begin
                r_quantum <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_want       <= n_want;
        r_k          <= n_k;
        r_res_status <= n_res_status;
        r_res_served <= n_res_served;
        r_res_slice  <= n_res_slice;
        r_res_done   <= n_res_done;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_served <= r_res_served;
            r_out_slice  <= r_res_slice;
            r_out_done   <= r_res_done;
            r_out_left   <= count_wide[rrts_pkg::LEFT_W-1:0];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_cur        = r_cur;
        n_count      = r_count;
        n_next_id    = r_next_id;
        n_want       = r_want;
        n_k          = r_k;
        n_res_status = r_res_status;
        n_res_served = r_res_served;
        n_res_slice  = r_res_slice;
        n_res_done   = r_res_done;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_raddr    = '0;
        drop_go      = 1'b0;
        drop_r       = '0;
        drop_cnt     = '0;
        drop_cur     = '0;

        case (r_state)
            rrts_pkg::S_IDLE: begin
                if (s_acc) begin
                    n_res_status = rrts_pkg::ST_OK;
                    n_res_served = '0;
                    n_res_slice  = '0;
                    n_res_done   = 1'b0;
                    n_state      = rrts_pkg::S_RESP;
                    case (in_func)
                        rrts_pkg::FUNC_ADD: begin
                            if (SUM_W'(r_count) >= SUM_W'(rrts_pkg::MAX_TASKS)) begin
                                n_res_status = rrts_pkg::ST_FULL;
                            end else if (in_burst == '0) begin
                                n_res_status = rrts_pkg::ST_ZERO_BURST;
                            end else begin
                                n_next_id    = r_next_id + 1'b1;
                                ram_we       = 1'b1;
                                ram_waddr    = rrts_pkg::slot_at(r_head, r_count);
                                ram_wdata    = '{id: n_next_id, burst: in_burst};
                                n_count      = r_count + 1'b1;
                                n_res_served = n_next_id;
                            end
                        end
                        rrts_pkg::FUNC_RUN: begin
                            if (r_count == '0) begin
                                n_res_status = rrts_pkg::ST_EMPTY;
                            end else begin
                                ram_raddr = rrts_pkg::slot_at(r_head, CNT_W'(r_cur));
                                n_state   = rrts_pkg::S_RUN;
                            end
                        end
                        rrts_pkg::FUNC_REMOVE: begin
                            if (r_count == '0) begin
                                n_res_status = rrts_pkg::ST_EMPTY;
                            end else begin
                                n_res_served = in_id;
                                n_want       = in_id;
                                n_k          = '0;
                                ram_raddr    = r_head;
                                n_state      = rrts_pkg::S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rrts_pkg::S_RUN: begin
                n_res_served = ram_rdata.id;
                if (ram_rdata.burst > rrts_pkg::BURST_W'(r_quantum)) begin
                    n_res_slice = r_quantum;
                    ram_we      = 1'b1;
                    ram_waddr   = rrts_pkg::slot_at(r_head, CNT_W'(r_cur));
                    ram_wdata   = '{id: ram_rdata.id,
                                    burst: ram_rdata.burst - rrts_pkg::BURST_W'(r_quantum)};
                    if (SUM_W'(r_cur) + 1'b1 >= SUM_W'(r_count)) begin
                        n_cur = '0;
                    end else begin
                        n_cur = r_cur + 1'b1;
                    end
                    n_state = rrts_pkg::S_RESP;
                end else begin
                    n_res_slice = ram_rdata.burst[rrts_pkg::QUANT_W-1:0];
                    n_res_done  = 1'b1;
                    drop_go     = 1'b1;
                    drop_r      = r_cur;
                end
            end
            rrts_pkg::S_SCAN: begin
                // read data belongs to offset r_k; the next offset is fetched meanwhile
                if (ram_rdata.id == r_want) begin
                    drop_go = 1'b1;
                    drop_r  = r_k;
                end else if (SUM_W'(r_k) + 1'b1 < SUM_W'(r_count)) begin
                    ram_raddr = rrts_pkg::slot_at(r_head, CNT_W'(r_k) + 1'b1);
                    n_k       = r_k + 1'b1;
                end else begin
                    n_res_status = rrts_pkg::ST_NOT_FOUND;
                    n_state      = rrts_pkg::S_RESP;
                end
            end
            rrts_pkg::S_SHIFT: begin
                // r_count is already the reduced count here
                ram_we    = 1'b1;
                ram_waddr = rrts_pkg::slot_at(r_head, CNT_W'(r_k));
                ram_wdata = ram_rdata;
                ram_raddr = rrts_pkg::slot_at(r_head, CNT_W'(r_k) + CNT_W'(2));
                n_k       = r_k + 1'b1;
                if (SUM_W'(r_k) + 1'b1 >= SUM_W'(r_count)) begin
                    n_state = rrts_pkg::S_RESP;
                end
            end
            rrts_pkg::S_RESP: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = rrts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rrts_pkg::S_IDLE;
            end
        endcase

        // take out the entry at offset drop_r; keep the turn on the task that followed it
        if (drop_go) begin
            drop_cnt = r_count - 1'b1;
            drop_cur = r_cur;
            if (drop_r == '0) begin
                if (r_cur != '0) begin
                    drop_cur = r_cur - 1'b1;
                end
            end else if (r_cur > drop_r) begin
                drop_cur = r_cur - 1'b1;
            end
            if (drop_cnt == '0 || SUM_W'(drop_cur) >= SUM_W'(drop_cnt)) begin
                drop_cur = '0;
            end
            n_count = drop_cnt;
            n_cur   = drop_cur;
            if (drop_r == '0) begin
                n_head  = rrts_pkg::slot_at(r_head, CNT_W'(1));
                n_state = rrts_pkg::S_RESP;
            end else if (SUM_W'(drop_r) < SUM_W'(drop_cnt)) begin
                ram_raddr = rrts_pkg::slot_at(r_head, CNT_W'(drop_r) + 1'b1);
                n_k       = drop_r;
                n_state   = rrts_pkg::S_SHIFT;
            end else begin
                n_state = rrts_pkg::S_RESP;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {2'b00, r_out_left, r_out_done, r_out_slice, r_out_served};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SUM_W'(r_count) <= SUM_W'(rrts_pkg::MAX_TASKS))
        else $error("task count above table size");

    a_cur_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_cur == '0))
        else $error("current position not at head on empty table");

    a_cur_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (SUM_W'(r_cur) < SUM_W'(r_count)))
        else $error("current position outside occupied ring");

    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrts_pkg::S_SHIFT) |-> (SUM_W'(r_k) < SUM_W'(r_count)))
        else $error("compaction past end of ring");

    a_resp_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_m_tvalid && r_state == rrts_pkg::S_IDLE))
        else $error("result not presented after response");
`endif

endmodule
